FILE: hw/rtl/matrix3x3_inverse_top_defines.svh
// ----------------------------------------------------------------------------
// matrix3x3_inverse_top_defines.svh
// Assertion macros used by the matrix inverse output stage (mi3_out)
// ----------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_TOP_DEFINES_SVH
`define MATRIX3X3_INVERSE_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define MI3_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mi3 same-cycle check failed");

// next-cycle implication, clocked on clk, off during rst
`define MI3_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mi3 next-cycle check failed");

`endif

FILE: hw/rtl/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// Types and constants of the 3x3 matrix inverse pipeline
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DIM           = 3;
  localparam int NLANE         = DIM * DIM;
  localparam int DATA_W        = 32;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int ADJ_W         = PROD_W + 1;
  localparam int AMAG_W        = PROD_W;
  localparam int TERM_W        = DATA_W + AMAG_W;
  localparam int DET_W         = TERM_W + 2;
  localparam int DMAG_W        = DET_W - 1;
  localparam int ABS_DET_W     = 63;
  localparam int QB            = DATA_W + 1;

  localparam int NXT [DIM] = '{1, 2, 0};
  localparam int PRV [DIM] = '{2, 0, 1};

  typedef struct packed {
    logic signed [DATA_W-1:0] m00;
    logic signed [DATA_W-1:0] m01;
    logic signed [DATA_W-1:0] m02;
    logic signed [DATA_W-1:0] m10;
    logic signed [DATA_W-1:0] m11;
    logic signed [DATA_W-1:0] m12;
    logic signed [DATA_W-1:0] m20;
    logic signed [DATA_W-1:0] m21;
    logic signed [DATA_W-1:0] m22;
  } mat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] inv00;
    logic signed [DATA_W-1:0] inv01;
    logic signed [DATA_W-1:0] inv02;
    logic signed [DATA_W-1:0] inv10;
    logic signed [DATA_W-1:0] inv11;
    logic signed [DATA_W-1:0] inv12;
    logic signed [DATA_W-1:0] inv20;
    logic signed [DATA_W-1:0] inv21;
    logic signed [DATA_W-1:0] inv22;
    logic [ABS_DET_W-1:0]     abs_det;
    logic                     singular;
  } res_t;

  typedef struct packed {
    logic                 det_zero;
    logic [NLANE-1:0]     neg;
    logic [ABS_DET_W-1:0] abs_det;
  } side_t;

endpackage

FILE: hw/rtl/mi3_front.sv
// ----------------------------------------------------------------------------
// mi3_front
// Adjugate, determinant and divider operands in nine pipeline stages
// ----------------------------------------------------------------------------
module mi3_front import mi3_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            mat_valid,
  input  mat_t                            mat,
  output logic                            vld_out,
  output logic [DMAG_W-1:0]               dmag,
  output logic [AMAG_W+2*FRAC_BITS-1:0]   num [NLANE],
  output side_t                           side
);

  localparam int NUM_W = AMAG_W + 2 * FRAC_BITS;
  localparam int SUM_W = DMAG_W + ABS_DET_W;

  logic signed [DATA_W-1:0] a [DIM][DIM];
  logic [8:0]               vld;
  logic signed [PROD_W-1:0] pp [NLANE];
  logic signed [PROD_W-1:0] pq [NLANE];
  logic signed [DATA_W-1:0] r0_0 [DIM];
  logic signed [DATA_W-1:0] r0_1 [DIM];
  logic signed [ADJ_W-1:0]  adj [NLANE];
  logic [AMAG_W-1:0]        amag [6][NLANE];
  logic                     aneg [5][NLANE];
  logic [DATA_W-1:0]        emag [DIM];
  logic [DIM-1:0]           eneg;
  logic [PROD_W-1:0]        plo [DIM];
  logic [PROD_W-1:0]        phi [DIM];
  logic [DIM-1:0]           tneg3;
  logic [DIM-1:0]           tneg4;
  logic [TERM_W-1:0]        tmag [DIM];
  logic signed [DET_W-1:0]  st [DIM];
  logic signed [DET_W-1:0]  det;
  logic [DMAG_W-1:0]        dmag7;
  logic                     dzero7;
  logic [NLANE-1:0]         neg7;
  logic [SUM_W-1:0]         rsum;
  logic [SUM_W-1:0]         rsh;
  logic [ABS_DET_W-1:0]     abs_det_next;

  assign a[0][0] = mat.m00;
  assign a[0][1] = mat.m01;
  assign a[0][2] = mat.m02;
  assign a[1][0] = mat.m10;
  assign a[1][1] = mat.m11;
  assign a[1][2] = mat.m12;
  assign a[2][0] = mat.m20;
  assign a[2][1] = mat.m21;
  assign a[2][2] = mat.m22;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[7:0], mat_valid};
    end
  end

  assign vld_out = vld[8];

  // round |det| to nearest, ties up, then saturate
  always_comb begin
    rsum = SUM_W'(dmag7) + (SUM_W'(1) << (2 * FRAC_BITS - 1));
    rsh  = rsum >> (2 * FRAC_BITS);
    abs_det_next = (|rsh[SUM_W-1:ABS_DET_W]) ? '1 : rsh[ABS_DET_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DIM; i++) begin
        for (int j = 0; j < DIM; j++) begin
          pp[i*DIM+j] <= a[NXT[j]][NXT[i]] * a[PRV[j]][PRV[i]];
          pq[i*DIM+j] <= a[PRV[j]][NXT[i]] * a[NXT[j]][PRV[i]];
        end
      end
      for (int k = 0; k < DIM; k++) begin
        r0_0[k] <= a[0][k];
        r0_1[k] <= r0_0[k];
        emag[k] <= r0_1[k][DATA_W-1] ? DATA_W'(-r0_1[k]) : DATA_W'(r0_1[k]);
        eneg[k] <= r0_1[k][DATA_W-1];
        plo[k] <= emag[k] * amag[0][k*DIM][DATA_W-1:0];
        phi[k] <= emag[k] * amag[0][k*DIM][AMAG_W-1:DATA_W];
        tneg3[k] <= eneg[k] ^ aneg[0][k*DIM];
        tmag[k] <= TERM_W'({phi[k], {DATA_W{1'b0}}}) + TERM_W'(plo[k]);
        tneg4[k] <= tneg3[k];
        st[k] <= tneg4[k] ? $signed(-DET_W'(tmag[k])) : $signed(DET_W'(tmag[k]));
      end
      for (int l = 0; l < NLANE; l++) begin
        adj[l] <= ADJ_W'(pp[l]) - ADJ_W'(pq[l]);
        amag[0][l] <= adj[l][ADJ_W-1] ? AMAG_W'(-adj[l]) : AMAG_W'(adj[l]);
        aneg[0][l] <= adj[l][ADJ_W-1];
        for (int s = 1; s < 6; s++) begin
          amag[s][l] <= amag[s-1][l];
        end
        for (int s = 1; s < 5; s++) begin
          aneg[s][l] <= aneg[s-1][l];
        end
        neg7[l] <= aneg[4][l] ^ det[DET_W-1];
        num[l] <= NUM_W'(amag[5][l]) << (2 * FRAC_BITS);
      end
      det <= st[0] + st[1] + st[2];
      dmag7 <= det[DET_W-1] ? DMAG_W'(-det) : DMAG_W'(det);
      dzero7 <= (det == '0);
      dmag <= dmag7;
      side.det_zero <= dzero7;
      side.neg <= neg7;
      side.abs_det <= abs_det_next;
    end
  end

endmodule

FILE: hw/rtl/mi3_div.sv
// ----------------------------------------------------------------------------
// mi3_div
// Nine restoring dividers, one quotient bit per stage, plus rounding stage
// ----------------------------------------------------------------------------
module mi3_div import mi3_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          vld_in,
  input  logic [DMAG_W-1:0]             dmag,
  input  logic [AMAG_W+2*FRAC_BITS-1:0] num [NLANE],
  input  side_t                         side,
  output logic                          vld_out,
  output logic [QB-1:0]                 q [NLANE],
  output logic                          rnd [NLANE],
  output side_t                         side_out
);

  localparam int NUM_W = AMAG_W + 2 * FRAC_BITS;
  localparam int RW    = (NUM_W > DMAG_W + QB) ? NUM_W : DMAG_W + QB;

  logic [RW-1:0]     rem [QB][NLANE];
  logic [QB-1:0]     qv [QB][NLANE];
  logic [DMAG_W-1:0] dv [QB];
  side_t             sv [QB];
  logic [QB:0]       vv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vv <= '0;
    end else if (en) begin
      vv <= {vv[QB-1:0], vld_in};
    end
  end

  assign vld_out = vv[QB];

  // top quotient bit flags a quotient of 2^32 or more
  for (genvar s = 0; s < QB; s++) begin : g_step
    localparam int SH = QB - 1 - s;
    logic [RW-1:0]     rin [NLANE];
    logic [QB-1:0]     qin [NLANE];
    logic [DMAG_W-1:0] din;
    side_t             sin;
    logic [RW:0]       dsh;
    logic [RW:0]       diff [NLANE];

    if (s == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < NLANE; l++) begin
          rin[l] = RW'(num[l]);
          qin[l] = '0;
        end
        din = dmag;
        sin = side;
      end
    end else begin : g_rest
      always_comb begin
        for (int l = 0; l < NLANE; l++) begin
          rin[l] = rem[s-1][l];
          qin[l] = qv[s-1][l];
        end
        din = dv[s-1];
        sin = sv[s-1];
      end
    end

    assign dsh = (RW + 1)'(din) << SH;

    always_comb begin
      for (int l = 0; l < NLANE; l++) begin
        diff[l] = {1'b0, rin[l]} - dsh;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < NLANE; l++) begin
          rem[s][l] <= diff[l][RW] ? rin[l] : diff[l][RW-1:0];
          qv[s][l]  <= {qin[l][QB-2:0], ~diff[l][RW]};
        end
        dv[s] <= din;
        sv[s] <= sin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NLANE; l++) begin
        q[l]   <= qv[QB-1][l];
        rnd[l] <= {rem[QB-1][l], 1'b0} >= (RW + 1)'(dv[QB-1]);
      end
      side_out <= sv[QB-1];
    end
  end

endmodule

FILE: hw/rtl/mi3_out.sv
// ----------------------------------------------------------------------------
// mi3_out
// Rounding and saturation of the inverse, output register and skid stage
// ----------------------------------------------------------------------------
`include "matrix3x3_inverse_top_defines.svh"

module mi3_out import mi3_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_vld,
  input  logic [QB-1:0] q [NLANE],
  input  logic          rnd [NLANE],
  input  side_t         side,
  output logic          up_ready,
  output logic          res_valid,
  input  logic          res_ready,
  output res_t          res
);

  localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MAX_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  logic [DATA_W-1:0] iv [NLANE];
  res_t              rnext;
  res_t              obuf;
  res_t              skid;
  logic              out_vld;
  logic              skid_vld;

  always_comb begin
    logic [DATA_W:0] qs;
    logic            sat;
    for (int l = 0; l < NLANE; l++) begin
      qs  = {1'b0, q[l][DATA_W-1:0]} + (DATA_W + 1)'(rnd[l]);
      sat = q[l][QB-1] | qs[DATA_W] | qs[DATA_W-1];
      if (side.det_zero) begin
        iv[l] = '0;
      end else if (side.neg[l]) begin
        iv[l] = sat ? MAX_NEG : DATA_W'(-qs);
      end else begin
        iv[l] = sat ? MAX_POS : qs[DATA_W-1:0];
      end
    end
    rnext.inv00    = iv[0];
    rnext.inv01    = iv[1];
    rnext.inv02    = iv[2];
    rnext.inv10    = iv[3];
    rnext.inv11    = iv[4];
    rnext.inv12    = iv[5];
    rnext.inv20    = iv[6];
    rnext.inv21    = iv[7];
    rnext.inv22    = iv[8];
    rnext.abs_det  = side.abs_det;
    rnext.singular = side.det_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (res_ready || !out_vld) begin
      if (skid_vld) begin
        out_vld  <= 1'b1;
        skid_vld <= 1'b0;
      end else begin
        out_vld <= up_vld;
      end
    end else if (up_vld && !skid_vld) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready || !out_vld) begin
      if (skid_vld) begin
        obuf <= skid;
      end else if (up_vld) begin
        obuf <= rnext;
      end
    end else if (up_vld && !skid_vld) begin
      skid <= rnext;
    end
  end

  assign up_ready  = ~skid_vld;
  assign res_valid = out_vld;
  assign res       = obuf;

  `MI3_ASSERT_IMP(a_skid_behind_out, skid_vld, out_vld)
  `MI3_ASSERT_NXT(a_skid_takes_stall, !skid_vld && out_vld && !res_ready && up_vld, skid_vld)
  `MI3_ASSERT_IMP(a_singular_zero, out_vld && obuf.singular, obuf.abs_det == '0 && obuf.inv00 == '0 && obuf.inv22 == '0)

endmodule

FILE: hw/rtl/matrix3x3_inverse_top.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse_top
// 3x3 fixed-point matrix inverse by adjugate and determinant
// ----------------------------------------------------------------------------
// A matrix of nine signed Q16.16 entries (row-major) is taken on the mat
// channel with a valid/ready transfer; the inverse entries, the absolute
// determinant and a singular flag leave on the res channel the same way.
// Throughput is one matrix per cycle while mat_ready is high. From the
// input transfer to res_valid, 9 stages form the adjugate and the
// determinant, 33 stages hold one quotient bit each of the nine parallel
// dividers, one stage rounds, and the output register follows.
// A zero determinant gives singular = 1 with zero entries and abs_det = 0.
// Reset clears every valid bit; the pipeline is empty afterwards and
// mat_ready is high.
// When the receiver stalls, the output register holds and a one-entry
// skid stage takes the next result; mat_ready drops only once the skid
// stage is full, and the whole pipeline then holds in place.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_top import mi3_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic mat_valid,
  output logic mat_ready,
  input  mat_t mat,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int NUM_W = AMAG_W + 2 * FRAC_BITS;

  logic              en;
  logic              f_vld;
  logic [DMAG_W-1:0] f_dmag;
  logic [NUM_W-1:0]  f_num [NLANE];
  side_t             f_side;
  logic              d_vld;
  logic [QB-1:0]     d_q [NLANE];
  logic              d_rnd [NLANE];
  side_t             d_side;

  assign mat_ready = en;

  mi3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .mat_valid (mat_valid),
    .mat       (mat),
    .vld_out   (f_vld),
    .dmag      (f_dmag),
    .num       (f_num),
    .side      (f_side)
  );

  mi3_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (f_vld),
    .dmag     (f_dmag),
    .num      (f_num),
    .side     (f_side),
    .vld_out  (d_vld),
    .q        (d_q),
    .rnd      (d_rnd),
    .side_out (d_side)
  );

  mi3_out u_out (
    .clk       (clk),
    .rst       (rst),
    .up_vld    (d_vld),
    .q         (d_q),
    .rnd       (d_rnd),
    .side      (d_side),
    .up_ready  (en),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule
